FILE: rtl/bprm_pkg.sv
// Shared constants for the block peak and RMS level meter.
// No dependencies; imported by every module of the meter.
package bprm_pkg;

  // Default configuration of the meter.
  localparam int unsigned MAX_BLOCK_DEF   = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Depth of the queue between accumulator and result unit.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Round a bit count up to whole bytes.
  function automatic int unsigned byte_round(input int unsigned bits);
    byte_round = ((bits + 7) / 8) * 8;
  endfunction

endpackage

FILE: rtl/bprm_front.sv
// Front end of the level meter: magnitude, square and per-block accumulation.
// Depends on bprm_pkg; pushes closed block statistics into bprm_queue.
module bprm_front
  import bprm_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_W     = $clog2(MAX_BLOCK + 1),
  parameter int unsigned SUM_W       = 2 * (SAMPLE_BITS - 1) + COUNT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [SAMPLE_BITS-1:0]        push_peak_o,
  output logic [SUM_W-1:0]              push_sum_o,
  output logic [COUNT_W-1:0]            push_count_o
);

  localparam int unsigned MAG_W = SAMPLE_BITS;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;

  logic                 adv;
  logic                 close;
  logic                 v1_q, v2_q;
  logic                 last1_q, last2_q;
  logic [MAG_W-1:0]     mag1_q, mag2_q;
  logic [SQ_W-1:0]      sq_q;
  logic [MAG_W-1:0]     mag_d;
  logic [2*MAG_W-1:0]   prod;
  logic [MAG_W-1:0]     peak_q, peak_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  // Two's complement magnitude; the most negative code maps to 2^(N-1).
  assign mag_d = sample_i[SAMPLE_BITS-1] ? (~sample_i + MAG_W'(1)) : sample_i;
  assign prod  = mag1_q * mag1_q;

  assign count_d = count_q + COUNT_W'(1);
  assign peak_d  = (mag2_q > peak_q) ? mag2_q : peak_q;
  assign sum_d   = sum_q + SUM_W'(sq_q);
  assign close   = last2_q || (count_d == COUNT_W'(MAX_BLOCK));

  // Hold the whole pipeline while a closing sample finds the queue full.
  assign adv        = !(v2_q && close && !push_ready_i);
  assign in_ready_o = adv;

  assign push_valid_o = v2_q && close;
  assign push_peak_o  = peak_d;
  assign push_sum_o   = sum_d;
  assign push_count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      peak_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      if (v2_q) begin
        if (close) begin
          peak_q  <= '0;
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          peak_q  <= peak_d;
          sum_q   <= sum_d;
          count_q <= count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag1_q  <= mag_d;
      last1_q <= last_i;
      mag2_q  <= mag1_q;
      last2_q <= last1_q;
      sq_q    <= prod[SQ_W-1:0];
    end
  end

endmodule

FILE: rtl/bprm_queue.sv
// Short register queue between accumulator and result unit.
// Depends on bprm_pkg for its default depth.
module bprm_queue
  import bprm_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  fill_q;
  logic              do_wr, do_rd;

  assign wr_ready_o = (fill_q != CNT_W'(DEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   fill_q <= fill_q + CNT_W'(1);
        2'b01:   fill_q <= fill_q - CNT_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/bprm_back.sv
// Result unit of the level meter: serial divide for the mean square, serial
// square root, and the output register. Depends on bprm_pkg.
module bprm_back
  import bprm_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_W     = $clog2(MAX_BLOCK + 1),
  parameter int unsigned SUM_W       = 2 * (SAMPLE_BITS - 1) + COUNT_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  logic [SAMPLE_BITS-1:0] pop_peak_i,
  input  logic [SUM_W-1:0]       pop_sum_i,
  input  logic [COUNT_W-1:0]     pop_count_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [SAMPLE_BITS-1:0] res_peak_o,
  output logic [SAMPLE_BITS-1:0] res_rms_o,
  output logic [COUNT_W-1:0]     res_count_o
);

  localparam int unsigned MAG_W  = SAMPLE_BITS;
  localparam int unsigned ROOT_W = (SUM_W + 1) / 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [MAG_W-1:0]    peak_q, peak_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [COUNT_W:0]    rem_q, rem_d;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [ROOT_W+1:0]   srem_q, srem_d;
  logic                out_valid_q, out_valid_d;
  logic [MAG_W-1:0]    out_peak_q, out_peak_d;
  logic [MAG_W-1:0]    out_rms_q, out_rms_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  logic [COUNT_W:0]    rem_sh, rem_diff;
  logic                div_bit;
  logic [ROOT_W+1:0]   srem_sh, trial, srem_diff;
  logic                root_bit;

  // One quotient bit per cycle (restoring division by the sample count).
  assign rem_sh   = {rem_q[COUNT_W-1:0], quo_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, count_q};
  assign div_bit  = (rem_sh >= {1'b0, count_q});

  // One root bit per cycle: bring down two radicand bits, try root*4+1.
  assign srem_sh   = {srem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial     = {root_q, 2'b01};
  assign srem_diff = srem_sh - trial;
  assign root_bit  = (srem_sh >= trial);

  assign pop_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_peak_o  = out_peak_q;
  assign res_rms_o   = out_rms_q;
  assign res_count_o = out_count_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    peak_d      = peak_q;
    count_d     = count_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    rad_d       = rad_q;
    root_d      = root_q;
    srem_d      = srem_q;
    out_valid_d = out_valid_q;
    out_peak_d  = out_peak_q;
    out_rms_d   = out_rms_q;
    out_count_d = out_count_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          peak_d  = pop_peak_i;
          count_d = pop_count_i;
          quo_d   = pop_sum_i;
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = div_bit ? rem_diff : rem_sh;
        quo_d  = {quo_q[SUM_W-2:0], div_bit};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (step_q == '0) begin
          // Load the mean square and clear the root and its remainder.
          rad_d  = RAD_W'(quo_q);
          root_d = '0;
          srem_d = '0;
          step_d = STEP_W'(1);
        end else begin
          srem_d = root_bit ? srem_diff : srem_sh;
          root_d = {root_q[ROOT_W-2:0], root_bit};
          rad_d  = {rad_q[RAD_W-3:0], 2'b00};
          step_d = step_q + STEP_W'(1);
          if (step_q == STEP_W'(ROOT_W)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_peak_d  = peak_q;
          out_rms_d   = root_q[MAG_W-1:0];
          out_count_d = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      peak_q      <= '0;
      count_q     <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      rad_q       <= '0;
      root_q      <= '0;
      srem_q      <= '0;
      out_valid_q <= 1'b0;
      out_peak_q  <= '0;
      out_rms_q   <= '0;
      out_count_q <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      peak_q      <= peak_d;
      count_q     <= count_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      rad_q       <= rad_d;
      root_q      <= root_d;
      srem_q      <= srem_d;
      out_valid_q <= out_valid_d;
      out_peak_q  <= out_peak_d;
      out_rms_q   <= out_rms_d;
      out_count_q <= out_count_d;
    end
  end

endmodule

FILE: rtl/block_peak_rms_meter_core.sv
// Block peak and RMS level meter. Samples are taken one per cycle, but the
// whole front stalls while a closing sample finds the queue full. The serial
// divide and square root take one closed block at a time, a new one only when
// idle; two closed blocks can wait in the queue.
// Reset is asynchronous, active low, clears all control state; no clearing pass.
module block_peak_rms_meter_core
  import bprm_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Sample stream
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // [SAMPLE_BITS-1:0] sample (signed), zero pad above
  input  logic [byte_round(SAMPLE_BITS)-1:0]             s_axis_tdata,
  // last_in_block
  input  logic                                           s_axis_tlast,
  // Result stream
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // peak_level, rms_level, block_samples from bit 0 up, zero pad above
  output logic [byte_round(2 * SAMPLE_BITS + $clog2(MAX_BLOCK + 1))-1:0] m_axis_tdata
);

  // Count must hold MAX_BLOCK itself; the sum holds MAX_BLOCK full-scale squares.
  localparam int unsigned COUNT_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W   = 2 * (SAMPLE_BITS - 1) + COUNT_W;
  localparam int unsigned ENTRY_W = SAMPLE_BITS + SUM_W + COUNT_W;
  localparam int unsigned RES_W   = 2 * SAMPLE_BITS + COUNT_W;
  localparam int unsigned M_W     = byte_round(RES_W);

  logic                   push_valid, push_ready;
  logic [SAMPLE_BITS-1:0] push_peak;
  logic [SUM_W-1:0]       push_sum;
  logic [COUNT_W-1:0]     push_count;
  logic                   pop_valid, pop_ready;
  logic [ENTRY_W-1:0]     pop_entry;
  logic [SAMPLE_BITS-1:0] res_peak, res_rms;
  logic [COUNT_W-1:0]     res_count;

  // Accumulate peak, sum of squares and count; close a block on tlast or
  // when the count reaches MAX_BLOCK.
  bprm_front #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_W     (COUNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i       (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_peak_o  (push_peak),
    .push_sum_o   (push_sum),
    .push_count_o (push_count)
  );

  // Buffer closed blocks so the front keeps taking samples while the
  // result unit works.
  bprm_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  ({push_count, push_sum, push_peak}),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_entry)
  );

  // Mean square by serial division, RMS by serial square root, then hold
  // the result in the output register until taken.
  bprm_back #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_W     (COUNT_W),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_peak_i  (pop_entry[SAMPLE_BITS-1:0]),
    .pop_sum_i   (pop_entry[SAMPLE_BITS+SUM_W-1:SAMPLE_BITS]),
    .pop_count_i (pop_entry[ENTRY_W-1:SAMPLE_BITS+SUM_W]),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_peak_o  (res_peak),
    .res_rms_o   (res_rms),
    .res_count_o (res_count)
  );

  // Pack the result, first field lowest.
  assign m_axis_tdata = M_W'({res_count, res_rms, res_peak});

endmodule
